### rtl/bnsc_pkg.sv
// shared types and constants of the image scaler
`default_nettype none
package bnsc_pkg;

  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int SIZE_REG_W = 10;
  localparam int STEP_W     = 26;
  localparam int INDEX_W    = 3;

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } mode_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_SCALE_MODE    = 3'd0,
    REG_SOURCE_WIDTH  = 3'd1,
    REG_SOURCE_HEIGHT = 3'd2,
    REG_X_STEP        = 3'd3,
    REG_Y_STEP        = 3'd4
  } reg_index_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [CHAN_W-1:0]   red_in;
    logic [CHAN_W-1:0]   green_in;
    logic [CHAN_W-1:0]   blue_in;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0]  out_column;
    logic [COORD_W-1:0]  out_row;
    logic [CHAN_W-1:0]   red_out;
    logic [CHAN_W-1:0]   green_out;
    logic [CHAN_W-1:0]   blue_out;
  } out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    mode_t                 scale_mode;
    logic [SIZE_REG_W-1:0] source_width;
    logic [SIZE_REG_W-1:0] source_height;
    logic [STEP_W-1:0]     x_step;
    logic [STEP_W-1:0]     y_step;
  } cfg_t;

  // bank parity of each neighbour column and row
  typedef struct packed {
    logic xb0;
    logic xb1;
    logic yb0;
    logic yb1;
  } nb_sel_t;

endpackage
`default_nettype wire

### rtl/bnsc_map.sv
// coordinate mapping: step multiply, source position, index clamp
`default_nettype none
module bnsc_map #(
  parameter int MAX_SRC_WIDTH  = 512,
  parameter int MAX_SRC_HEIGHT = 512,
  parameter int FRAC_BITS      = 16,
  localparam int XW = $clog2(MAX_SRC_WIDTH),
  localparam int YW = $clog2(MAX_SRC_HEIGHT)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             item_valid,
  input  wire bnsc_pkg::in_t    item,
  input  wire bnsc_pkg::cfg_t   cfg,
  output logic                  b_valid,
  output bnsc_pkg::in_t         b_item,
  output logic [XW-1:0]         b_x0,
  output logic [XW-1:0]         b_x1,
  output logic [YW-1:0]         b_y0,
  output logic [YW-1:0]         b_y1,
  output logic [FRAC_BITS-1:0]  b_u,
  output logic [FRAC_BITS-1:0]  b_v
);

  localparam int MW  = bnsc_pkg::COORD_W + 1;
  localparam int PW  = MW + bnsc_pkg::STEP_W;
  localparam int IXW = PW - FRAC_BITS;
  localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int EWX = (SWW > bnsc_pkg::SIZE_REG_W) ? SWW : bnsc_pkg::SIZE_REG_W;
  localparam int EWY = (SHW > bnsc_pkg::SIZE_REG_W) ? SHW : bnsc_pkg::SIZE_REG_W;

  logic            bil;
  logic [MW-1:0]   mc_x, mc_y;
  logic            a_valid;
  bnsc_pkg::in_t   a_item;
  logic [PW-1:0]   a_px, a_py;
  logic [PW-1:0]   one_p, pos_x, pos_y;
  logic [EWX-1:0]  w_ext;
  logic [EWY-1:0]  h_ext;
  logic [SWW-1:0]  w_eff, w_last;
  logic [SHW-1:0]  h_eff, h_last;
  logic [IXW-1:0]  ix, iy;
  logic [XW-1:0]   x0_next, x1_next;
  logic [YW-1:0]   y0_next, y1_next;

  assign bil = (cfg.scale_mode == bnsc_pkg::MODE_BILINEAR);

  // multiplier operand: 2c+1 for bilinear, c for nearest
  always_comb begin
    if (bil) begin
      mc_x = {item.column, 1'b1};
      mc_y = {item.row, 1'b1};
    end else begin
      mc_x = {1'b0, item.column};
      mc_y = {1'b0, item.row};
    end
  end

  // stage a: step products
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= item;
      a_px   <= PW'(mc_x) * PW'(cfg.x_step);
      a_py   <= PW'(mc_y) * PW'(cfg.y_step);
    end
  end

  // effective source size and source position
  always_comb begin
    w_ext = EWX'(cfg.source_width);
    h_ext = EWY'(cfg.source_height);
    if (cfg.source_width == '0) begin
      w_eff = SWW'(1);
    end else if (w_ext > EWX'(MAX_SRC_WIDTH)) begin
      w_eff = SWW'(MAX_SRC_WIDTH);
    end else begin
      w_eff = SWW'(w_ext);
    end
    if (cfg.source_height == '0) begin
      h_eff = SHW'(1);
    end else if (h_ext > EWY'(MAX_SRC_HEIGHT)) begin
      h_eff = SHW'(MAX_SRC_HEIGHT);
    end else begin
      h_eff = SHW'(h_ext);
    end
    w_last = w_eff - SWW'(1);
    h_last = h_eff - SHW'(1);

    one_p = PW'(1) << FRAC_BITS;
    if (bil) begin
      pos_x = (a_px < one_p) ? '0 : ((a_px - one_p) >> 1);
      pos_y = (a_py < one_p) ? '0 : ((a_py - one_p) >> 1);
    end else begin
      pos_x = a_px;
      pos_y = a_py;
    end
    ix = IXW'(pos_x >> FRAC_BITS);
    iy = IXW'(pos_y >> FRAC_BITS);

    // clamp both neighbours to the last source column and row
    x0_next = (ix >= IXW'(w_eff)) ? XW'(w_last) : XW'(ix);
    y0_next = (iy >= IXW'(h_eff)) ? YW'(h_last) : YW'(iy);
    if (bil && (({1'b0, ix} + (IXW+1)'(1)) < (IXW+1)'(w_eff))) begin
      x1_next = XW'(ix + IXW'(1));
    end else if (bil) begin
      x1_next = XW'(w_last);
    end else begin
      x1_next = x0_next;
    end
    if (bil && (({1'b0, iy} + (IXW+1)'(1)) < (IXW+1)'(h_eff))) begin
      y1_next = YW'(iy + IXW'(1));
    end else if (bil) begin
      y1_next = YW'(h_last);
    end else begin
      y1_next = y0_next;
    end
  end

  // stage b: clamped indices and fractions
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_item <= a_item;
      b_x0   <= x0_next;
      b_x1   <= x1_next;
      b_y0   <= y0_next;
      b_y1   <= y1_next;
      b_u    <= bil ? pos_x[FRAC_BITS-1:0] : '0;
      b_v    <= bil ? pos_y[FRAC_BITS-1:0] : '0;
    end
  end

  // checks
  a_nearest_single: assert property (@(posedge clk) disable iff (rst)
    a_valid && en && (cfg.scale_mode == bnsc_pkg::MODE_NEAREST)
    |=> (b_x1 == b_x0) && (b_y1 == b_y0) && (b_u == '0) && (b_v == '0))
    else $error("nearest item carries a second neighbour or a fraction");

  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> ((b_x1 == b_x0) || (b_x1 == XW'(b_x0 + XW'(1))))
             && ((b_y1 == b_y0) || (b_y1 == YW'(b_y0 + YW'(1)))))
    else $error("neighbour indices not adjacent");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    a_valid && en |=> b_valid)
    else $error("item lost between mapping stages");

endmodule
`default_nettype wire

### rtl/bnsc_frame.sv
// source frame store: four banks by column and row parity
`default_nettype none
module bnsc_frame #(
  parameter int MAX_SRC_WIDTH  = 512,
  parameter int MAX_SRC_HEIGHT = 512,
  localparam int XW = $clog2(MAX_SRC_WIDTH),
  localparam int YW = $clog2(MAX_SRC_HEIGHT)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    b_valid,
  input  wire bnsc_pkg::in_t           b_item,
  input  wire logic [XW-1:0]           b_x0,
  input  wire logic [XW-1:0]           b_x1,
  input  wire logic [YW-1:0]           b_y0,
  input  wire logic [YW-1:0]           b_y1,
  output logic                         c_valid,
  output logic [bnsc_pkg::COORD_W-1:0] c_column,
  output logic [bnsc_pkg::COORD_W-1:0] c_row,
  output bnsc_pkg::pixel_t [3:0]       c_pix,
  output bnsc_pkg::nb_sel_t            c_sel
);

  localparam int BCW = (XW > 1) ? XW - 1 : 1;
  localparam int BRW = (YW > 1) ? YW - 1 : 1;
  localparam int AW  = BCW + BRW;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int CMW = bnsc_pkg::COORD_W + 1;

  logic          in_frame;
  logic [1:0]    wbank;
  logic [AW-1:0] waddr;
  bnsc_pkg::pixel_t wdata;

  // store address inside the banked frame
  always_comb begin
    in_frame = ({1'b0, b_item.column} < CMW'(MAX_SRC_WIDTH))
            && ({1'b0, b_item.row} < CMW'(MAX_SRC_HEIGHT));
    wbank = {b_item.row[0], b_item.column[0]};
    waddr = {BRW'(b_item.row >> 1), BCW'(b_item.column >> 1)};
    wdata = '{red: b_item.red_in, green: b_item.green_in, blue: b_item.blue_in};
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic PX = k[0];
    localparam logic PY = k[1];
    bnsc_pkg::pixel_t mem [BANK_DEPTH];
    logic [XW-1:0] xs;
    logic [YW-1:0] ys;
    logic [AW-1:0] raddr;
    logic          we;

    // pick the neighbour column and row that fall in this bank
    always_comb begin
      xs    = (b_x0[0] == PX) ? b_x0 : b_x1;
      ys    = (b_y0[0] == PY) ? b_y0 : b_y1;
      raddr = {BRW'(ys >> 1), BCW'(xs >> 1)};
      we    = en && b_valid && (b_item.opcode == bnsc_pkg::OP_STORE) && in_frame
           && (wbank == 2'(k));
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_pix[k] <= mem[raddr];
      end
    end
  end

  // stage c: only compute items go on
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid && (b_item.opcode == bnsc_pkg::OP_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_column  <= b_item.column;
      c_row     <= b_item.row;
      c_sel.xb0 <= b_x0[0];
      c_sel.xb1 <= (b_x1 == b_x0) ? b_x0[0] : ~b_x0[0];
      c_sel.yb0 <= b_y0[0];
      c_sel.yb1 <= (b_y1 == b_y0) ? b_y0[0] : ~b_y0[0];
    end
  end

endmodule
`default_nettype wire

### rtl/bnsc_blend.sv
// weights, neighbour products and weighted sum into the result register
`default_nettype none
module bnsc_blend #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [FRAC_BITS-1:0]          b_u,
  input  wire logic [FRAC_BITS-1:0]          b_v,
  input  wire logic                          c_valid,
  input  wire logic [bnsc_pkg::COORD_W-1:0]  c_column,
  input  wire logic [bnsc_pkg::COORD_W-1:0]  c_row,
  input  wire bnsc_pkg::pixel_t [3:0]        c_pix,
  input  wire bnsc_pkg::nb_sel_t             c_sel,
  output logic                               result_valid,
  output bnsc_pkg::out_t                     result
);

  localparam int FW  = FRAC_BITS + 1;
  localparam int WW  = 2 * FRAC_BITS + 1;
  localparam int PRW = WW + bnsc_pkg::CHAN_W;
  localparam int SMW = PRW + 2;
  localparam int CW  = bnsc_pkg::CHAN_W;

  logic [FW-1:0]  ou, ov;
  logic [WW-1:0]  c_w [4];
  bnsc_pkg::pixel_t nb [4];
  logic [CW-1:0]  ch [3][4];
  logic           d_valid;
  logic [bnsc_pkg::COORD_W-1:0] d_column, d_row;
  logic [PRW-1:0] d_prod [3][4];
  logic [SMW-1:0] sum [3];
  logic [CW-1:0]  chan_out [3];

  // stage c: neighbour weights, alongside the frame read
  always_comb begin
    ou = (FW'(1) << FRAC_BITS) - FW'(b_u);
    ov = (FW'(1) << FRAC_BITS) - FW'(b_v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_w[0] <= WW'(ou * ov);
      c_w[1] <= WW'(FW'(b_u) * ov);
      c_w[2] <= WW'(ou * FW'(b_v));
      c_w[3] <= WW'(FW'(b_u) * FW'(b_v));
    end
  end

  // neighbour order: (x0,y0), (x1,y0), (x0,y1), (x1,y1)
  always_comb begin
    nb[0] = c_pix[{c_sel.yb0, c_sel.xb0}];
    nb[1] = c_pix[{c_sel.yb0, c_sel.xb1}];
    nb[2] = c_pix[{c_sel.yb1, c_sel.xb0}];
    nb[3] = c_pix[{c_sel.yb1, c_sel.xb1}];
    for (int n = 0; n < 4; n++) begin
      ch[0][n] = nb[n].red;
      ch[1][n] = nb[n].green;
      ch[2][n] = nb[n].blue;
    end
  end

  // stage d: weight times channel
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_column <= c_column;
      d_row    <= c_row;
      for (int c = 0; c < 3; c++) begin
        for (int n = 0; n < 4; n++) begin
          d_prod[c][n] <= PRW'(c_w[n]) * PRW'(ch[c][n]);
        end
      end
    end
  end

  // sum, truncate, saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SMW'(d_prod[c][0]) + SMW'(d_prod[c][1])
             + SMW'(d_prod[c][2]) + SMW'(d_prod[c][3]);
      if ((sum[c] >> (2 * FRAC_BITS)) > SMW'(255)) begin
        chan_out[c] = '1;
      end else begin
        chan_out[c] = CW'(sum[c] >> (2 * FRAC_BITS));
      end
    end
  end

  // stage e: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.out_column <= d_column;
      result.out_row    <= d_row;
      result.red_out    <= chan_out[0];
      result.green_out  <= chan_out[1];
      result.blue_out   <= chan_out[2];
    end
  end

endmodule
`default_nettype wire

### rtl/bilinear_nearest_image_scaler_unit.sv
// top level of the image scaler: configuration registers and pipeline
// a computed result passes through stages a to d and then the result register
// throughput: one item per cycle; every stage moves together and holds
//   while a waiting result is stalled
// stores take effect in the third stage, in order with computes
// reset clears the pipeline and sets the configuration registers; the frame is not cleared
`default_nettype none
module bilinear_nearest_image_scaler_unit #(
  parameter int MAX_SRC_WIDTH  = 512,
  parameter int MAX_SRC_HEIGHT = 512,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire bnsc_pkg::in_t                 item,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output bnsc_pkg::out_t                     result,
  input  wire logic                          cfg_write,
  input  wire logic [bnsc_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [bnsc_pkg::STEP_W-1:0]   cfg_data
);

  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);

  bnsc_pkg::cfg_t            cfg;
  logic                      en;
  logic                      b_valid;
  bnsc_pkg::in_t             b_item;
  logic [XW-1:0]             b_x0, b_x1;
  logic [YW-1:0]             b_y0, b_y1;
  logic [FRAC_BITS-1:0]      b_u, b_v;
  logic                      c_valid;
  logic [bnsc_pkg::COORD_W-1:0] c_column, c_row;
  bnsc_pkg::pixel_t [3:0]    c_pix;
  bnsc_pkg::nb_sel_t         c_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_mode    <= bnsc_pkg::MODE_BILINEAR;
      cfg.source_width  <= 10'd512;
      cfg.source_height <= 10'd512;
      cfg.x_step        <= 26'd65536;
      cfg.y_step        <= 26'd65536;
    end else if (cfg_write) begin
      unique case (bnsc_pkg::reg_index_t'(cfg_index))
        bnsc_pkg::REG_SCALE_MODE: begin
          cfg.scale_mode <= bnsc_pkg::mode_t'(cfg_data[0]);
        end
        bnsc_pkg::REG_SOURCE_WIDTH: begin
          cfg.source_width <= cfg_data[bnsc_pkg::SIZE_REG_W-1:0];
        end
        bnsc_pkg::REG_SOURCE_HEIGHT: begin
          cfg.source_height <= cfg_data[bnsc_pkg::SIZE_REG_W-1:0];
        end
        bnsc_pkg::REG_X_STEP: begin
          cfg.x_step <= cfg_data;
        end
        bnsc_pkg::REG_Y_STEP: begin
          cfg.y_step <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline advance
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  bnsc_map #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .item_valid(item_valid),
    .item      (item),
    .cfg       (cfg),
    .b_valid   (b_valid),
    .b_item    (b_item),
    .b_x0      (b_x0),
    .b_x1      (b_x1),
    .b_y0      (b_y0),
    .b_y1      (b_y1),
    .b_u       (b_u),
    .b_v       (b_v)
  );

  bnsc_frame #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .b_valid (b_valid),
    .b_item  (b_item),
    .b_x0    (b_x0),
    .b_x1    (b_x1),
    .b_y0    (b_y0),
    .b_y1    (b_y1),
    .c_valid (c_valid),
    .c_column(c_column),
    .c_row   (c_row),
    .c_pix   (c_pix),
    .c_sel   (c_sel)
  );

  bnsc_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .b_u         (b_u),
    .b_v         (b_v),
    .c_valid     (c_valid),
    .c_column    (c_column),
    .c_row       (c_row),
    .c_pix       (c_pix),
    .c_sel       (c_sel),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
`default_nettype wire

### bench/tb.sv
// self-checking testbench of the image scaler: directed table, then random phases
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int MAX_W = 512;
  localparam int MAX_H = 512;
  localparam int FRAC = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned FMASK = ONE - 1;
  localparam logic [bnsc_pkg::INDEX_W-1:0] BAD_INDEX = 3'd7;
  localparam logic [bnsc_pkg::STEP_W-1:0] STEP_MAX = '1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 150;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [bnsc_pkg::INDEX_W-1:0] idx;
    logic [bnsc_pkg::STEP_W-1:0] data;
    bnsc_pkg::in_t it;
    bit chk;
    bnsc_pkg::pixel_t pix;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  bnsc_pkg::in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  bnsc_pkg::out_t result;
  logic cfg_write = 1'b0;
  logic [bnsc_pkg::INDEX_W-1:0] cfg_index = '0;
  logic [bnsc_pkg::STEP_W-1:0] cfg_data = '0;

  // shadow configuration and frame
  bnsc_pkg::mode_t cfg_mode = bnsc_pkg::MODE_BILINEAR;
  logic [bnsc_pkg::SIZE_REG_W-1:0] cfg_w = 10'd512;
  logic [bnsc_pkg::SIZE_REG_W-1:0] cfg_h = 10'd512;
  logic [bnsc_pkg::STEP_W-1:0] cfg_xs = 26'd65536;
  logic [bnsc_pkg::STEP_W-1:0] cfg_ys = 26'd65536;
  bnsc_pkg::pixel_t frame [MAX_W*MAX_H];
  bit written [MAX_W*MAX_H];

  bnsc_pkg::out_t pending_pixels[$];
  plan_row_t plan[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  bilinear_nearest_image_scaler_unit u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // receiver: check each result transfer and decide the next stall
  always @(posedge clk) begin
    bnsc_pkg::out_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_pixels.size() == 0) begin
          report($sformatf("unexpected result %h", result));
        end else begin
          want = pending_pixels.pop_front();
          if (result.out_column !== want.out_column)
            report($sformatf("column %h want %h", result.out_column, want.out_column));
          if (result.out_row !== want.out_row)
            report($sformatf("row %h want %h", result.out_row, want.out_row));
          if (result.red_out !== want.red_out)
            report($sformatf("red %h want %h", result.red_out, want.red_out));
          if (result.green_out !== want.green_out)
            report($sformatf("green %h want %h", result.green_out, want.green_out));
          if (result.blue_out !== want.blue_out)
            report($sformatf("blue %h want %h", result.blue_out, want.blue_out));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic longint unsigned size_of(input logic [bnsc_pkg::SIZE_REG_W-1:0] sz,
                                              input int maxv);
    if (sz == 0) return 1;
    return (sz > maxv) ? maxv : sz;
  endfunction

  function automatic int clamp_to(input longint unsigned i, input longint unsigned sz);
    return int'((i >= sz) ? sz - 1 : i);
  endfunction

  function automatic longint unsigned centre_pos(input logic [bnsc_pkg::COORD_W-1:0] c,
                                                 input logic [bnsc_pkg::STEP_W-1:0] s);
    longint unsigned t;
    t = (2 * 64'(c) + 1) * 64'(s);
    if (t < ONE) return 0;
    return (t - ONE) >> 1;
  endfunction

  // source neighbours and fractions; nearest mode is the zero-fraction case
  function automatic void locate(input logic [bnsc_pkg::COORD_W-1:0] c, r,
                                 output int x0, x1, y0, y1,
                                 output longint unsigned u, v);
    longint unsigned w, h, px, py;
    w = size_of(cfg_w, MAX_W);
    h = size_of(cfg_h, MAX_H);
    if (cfg_mode == bnsc_pkg::MODE_NEAREST) begin
      px = (64'(c) * 64'(cfg_xs)) & ~FMASK;
      py = (64'(r) * 64'(cfg_ys)) & ~FMASK;
    end else begin
      px = centre_pos(c, cfg_xs);
      py = centre_pos(r, cfg_ys);
    end
    u = px & FMASK;
    v = py & FMASK;
    x0 = clamp_to(px >> FRAC, w);
    y0 = clamp_to(py >> FRAC, h);
    x1 = clamp_to((px >> FRAC) + 1, w);
    y1 = clamp_to((py >> FRAC) + 1, h);
  endfunction

  function automatic logic [bnsc_pkg::CHAN_W-1:0] blend(
      input logic [bnsc_pkg::CHAN_W-1:0] a, b, c, d,
      input longint unsigned u, v);
    longint unsigned s;
    s = (ONE - u) * (ONE - v) * a + u * (ONE - v) * b + (ONE - u) * v * c + u * v * d;
    s = s >> (2 * FRAC);
    return (s > 255) ? 8'd255 : s[bnsc_pkg::CHAN_W-1:0];
  endfunction

  // update the shadow frame or work out the pixel for one accepted item
  function automatic void scale_pixel(input bnsc_pkg::in_t it, input bit keep);
    int x0, x1, y0, y1;
    longint unsigned u, v;
    bnsc_pkg::pixel_t p00, p10, p01, p11;
    bnsc_pkg::out_t o;
    if (it.opcode == bnsc_pkg::OP_STORE) begin
      if (it.column < MAX_W && it.row < MAX_H) begin
        frame[it.row * MAX_W + it.column] = '{it.red_in, it.green_in, it.blue_in};
        written[it.row * MAX_W + it.column] = 1'b1;
      end
      return;
    end
    locate(it.column, it.row, x0, x1, y0, y1, u, v);
    p00 = frame[y0 * MAX_W + x0];
    p10 = frame[y0 * MAX_W + x1];
    p01 = frame[y1 * MAX_W + x0];
    p11 = frame[y1 * MAX_W + x1];
    if (cfg_mode == bnsc_pkg::MODE_NEAREST) begin
      p10 = p00;
      p01 = p00;
      p11 = p00;
    end
    o.out_column = it.column;
    o.out_row = it.row;
    o.red_out = blend(p00.red, p10.red, p01.red, p11.red, u, v);
    o.green_out = blend(p00.green, p10.green, p01.green, p11.green, u, v);
    o.blue_out = blend(p00.blue, p10.blue, p01.blue, p11.blue, u, v);
    if (keep) pending_pixels.push_back(o);
  endfunction

  // one input transfer, with random gaps before it
  task automatic send(input bnsc_pkg::in_t it, input bit keep);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    scale_pixel(it, keep);
  endtask

  function automatic bnsc_pkg::in_t pixel_item(input bnsc_pkg::opcode_t op,
                                               input logic [bnsc_pkg::COORD_W-1:0] c, r,
                                               input bnsc_pkg::pixel_t p);
    bnsc_pkg::in_t it;
    it.opcode = op;
    it.column = c;
    it.row = r;
    it.red_in = p.red;
    it.green_in = p.green;
    it.blue_in = p.blue;
    return it;
  endfunction

  // store random pixels wherever a compute would read an unwritten entry
  task automatic fill_sites(input logic [bnsc_pkg::COORD_W-1:0] c, r);
    int x0, x1, y0, y1;
    int xs [4];
    int ys [4];
    longint unsigned u, v;
    locate(c, r, x0, x1, y0, y1, u, v);
    xs = '{x0, x1, x0, x1};
    ys = '{y0, y0, y1, y1};
    for (int k = 0; k < 4; k++)
      if (!written[ys[k] * MAX_W + xs[k]])
        send(pixel_item(bnsc_pkg::OP_STORE, bnsc_pkg::COORD_W'(xs[k]),
                        bnsc_pkg::COORD_W'(ys[k]), bnsc_pkg::pixel_t'($urandom)), 1'b0);
  endtask

  task automatic compute(input logic [bnsc_pkg::COORD_W-1:0] c, r);
    fill_sites(c, r);
    send(pixel_item(bnsc_pkg::OP_COMPUTE, c, r, bnsc_pkg::pixel_t'($urandom)), 1'b1);
  endtask

  // wait until the pipeline has drained
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bnsc_pkg::INDEX_W-1:0] idx,
                           input logic [bnsc_pkg::STEP_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      bnsc_pkg::REG_SCALE_MODE:    cfg_mode = bnsc_pkg::mode_t'(data[0]);
      bnsc_pkg::REG_SOURCE_WIDTH:  cfg_w = data[bnsc_pkg::SIZE_REG_W-1:0];
      bnsc_pkg::REG_SOURCE_HEIGHT: cfg_h = data[bnsc_pkg::SIZE_REG_W-1:0];
      bnsc_pkg::REG_X_STEP:        cfg_xs = data;
      bnsc_pkg::REG_Y_STEP:        cfg_ys = data;
      default: ;
    endcase
  endtask

  function automatic void plan_cfg(input logic [bnsc_pkg::INDEX_W-1:0] idx,
                                   input logic [bnsc_pkg::STEP_W-1:0] d);
    plan.push_back('{ROW_CFG, idx, d, '0, 1'b0, '0});
  endfunction

  function automatic void plan_item(input bnsc_pkg::opcode_t op,
                                    input logic [bnsc_pkg::COORD_W-1:0] c, r,
                                    input bit chk, input bnsc_pkg::pixel_t p);
    plan.push_back('{ROW_ITEM, bnsc_pkg::REG_SCALE_MODE, '0, pixel_item(op, c, r, p), chk, p});
  endfunction

  function automatic logic [bnsc_pkg::SIZE_REG_W-1:0] pick_size();
    return ($urandom_range(9) < 7) ? $urandom_range(1, 20) : $urandom_range(1023);
  endfunction

  function automatic logic [bnsc_pkg::STEP_W-1:0] pick_step(
      input logic [bnsc_pkg::SIZE_REG_W-1:0] sz);
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return (26'(sz) << FRAC) / $urandom_range(1, 24);
    if (sel < 8) return $urandom;
    return (sel == 8) ? '0 : STEP_MAX;
  endfunction

  function automatic logic [bnsc_pkg::COORD_W-1:0] pick_coord(
      input logic [bnsc_pkg::SIZE_REG_W-1:0] sz);
    return ($urandom_range(9) < 8) ? $urandom_range(0, 26'(sz) + 2) : $urandom_range(4095);
  endfunction

  initial begin
    bnsc_pkg::in_t it;
    logic [bnsc_pkg::SIZE_REG_W-1:0] w, h;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, frame corners, ignored stores, size and step extremes
    plan_item(bnsc_pkg::OP_STORE, 0, 0, 1'b0, 24'hFF0080);
    plan_item(bnsc_pkg::OP_COMPUTE, 0, 0, 1'b1, 24'hFF0080);
    plan_item(bnsc_pkg::OP_STORE, 511, 511, 1'b0, 24'h010203);
    plan_item(bnsc_pkg::OP_COMPUTE, 4095, 4095, 1'b1, 24'h010203);
    plan_item(bnsc_pkg::OP_STORE, 511, 0, 1'b0, 24'h123456);
    plan_item(bnsc_pkg::OP_STORE, 4095, 0, 1'b0, 24'hAAAAAA);
    plan_item(bnsc_pkg::OP_STORE, 0, 4095, 1'b0, 24'h555555);
    plan_item(bnsc_pkg::OP_COMPUTE, 4095, 0, 1'b1, 24'h123456);
    plan_cfg(bnsc_pkg::REG_X_STEP, 26'd32768);
    plan_item(bnsc_pkg::OP_COMPUTE, 1, 0, 1'b0, '0);
    plan_item(bnsc_pkg::OP_COMPUTE, 3, 2, 1'b0, '0);
    plan_cfg(bnsc_pkg::REG_SCALE_MODE, bnsc_pkg::MODE_NEAREST);
    plan_item(bnsc_pkg::OP_COMPUTE, 5, 3, 1'b0, '0);
    plan_cfg(bnsc_pkg::REG_SOURCE_WIDTH, 10'd0);
    plan_item(bnsc_pkg::OP_COMPUTE, 100, 0, 1'b1, 24'hFF0080);
    plan_cfg(bnsc_pkg::REG_X_STEP, '0);
    plan_cfg(bnsc_pkg::REG_Y_STEP, '0);
    plan_cfg(BAD_INDEX, STEP_MAX);
    plan_item(bnsc_pkg::OP_COMPUTE, 4095, 4095, 1'b1, 24'hFF0080);
    plan_cfg(bnsc_pkg::REG_SCALE_MODE, bnsc_pkg::MODE_BILINEAR);
    plan_item(bnsc_pkg::OP_COMPUTE, 4095, 4095, 1'b1, 24'hFF0080);
    plan_cfg(bnsc_pkg::REG_SOURCE_WIDTH, 10'd1023);
    plan_cfg(bnsc_pkg::REG_SOURCE_HEIGHT, 10'd1023);
    plan_cfg(bnsc_pkg::REG_X_STEP, STEP_MAX);
    plan_cfg(bnsc_pkg::REG_Y_STEP, STEP_MAX);
    plan_item(bnsc_pkg::OP_COMPUTE, 4095, 4095, 1'b1, 24'h010203);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
        cfg_write <= 1'b0;
      end else if (plan[i].it.opcode == bnsc_pkg::OP_STORE) begin
        send(plan[i].it, 1'b0);
      end else if (plan[i].chk) begin
        // zero-weight neighbours are still read, so they must hold data
        fill_sites(plan[i].it.column, plan[i].it.row);
        send(plan[i].it, 1'b0);
        pending_pixels.push_back('{plan[i].it.column, plan[i].it.row,
                                   plan[i].pix.red, plan[i].pix.green, plan[i].pix.blue});
      end else begin
        fill_sites(plan[i].it.column, plan[i].it.row);
        send(plan[i].it, 1'b1);
      end
    end

    // random phases, each with fresh settings and one of four idling and stalling patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      w = pick_size();
      h = pick_size();
      write_reg(bnsc_pkg::REG_SCALE_MODE, $urandom_range(1));
      write_reg(bnsc_pkg::REG_SOURCE_WIDTH, w);
      write_reg(bnsc_pkg::REG_SOURCE_HEIGHT, h);
      write_reg(bnsc_pkg::REG_X_STEP, pick_step(w));
      write_reg(bnsc_pkg::REG_Y_STEP, pick_step(h));
      cfg_write <= 1'b0;
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      // long receiver hold-off while items keep coming
      if (ph == 4) hold_left = 300;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(3) == 0) begin
          it = pixel_item(bnsc_pkg::OP_STORE, pick_coord(w), pick_coord(h),
                          bnsc_pkg::pixel_t'($urandom));
          send(it, 1'b0);
        end else begin
          compute(pick_coord(w), pick_coord(h));
        end
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    foreach (pending_pixels[i])
      report($sformatf("missing result for column %h row %h",
                       pending_pixels[i].out_column, pending_pixels[i].out_row));
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
